>>> rtl/oscillator_lock_supervisor_assert.svh
// Assertion macros of the oscillator lock supervisor checker.
`ifndef OSCILLATOR_LOCK_SUPERVISOR_ASSERT_SVH
`define OSCILLATOR_LOCK_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define OLSUP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olsup assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define OLSUP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olsup assertion failed");

`endif

>>> rtl/olsup_pkg.sv
// Package: types, constants and helpers of the oscillator lock supervisor.
`default_nettype none

package olsup_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [14:0] PHASE_TOL_RESET   = 15'd32;
    localparam logic [7:0]  DWELL_LIMIT_RESET = 8'd100;
    localparam logic [7:0]  ENABLE_DLY_RESET  = 8'd15;
    localparam logic [15:0] DEFAULT_DAC       = 16'd23000;
    localparam logic [7:0]  UTC_ALL_VALID     = 8'h07;
    localparam logic [7:0]  DWELL_TOP         = 8'hFF;
    localparam logic [7:0]  SAVE_HIGH_SECOND  = 8'd1;
    localparam logic [7:0]  SAVE_LOW_SECOND   = 8'd2;
    localparam int          AVG_SHIFT         = 4;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_TOLERANCE = 3'd0,
        CFG_DWELL_LIMIT     = 3'd1,
        CFG_ENABLE_DELAY    = 3'd2,
        CFG_STARTUP_DAC     = 3'd3,
        CFG_VIDEO_STANDARD  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [14:0] phase_tolerance;
        logic [7:0]  dwell_limit;
        logic [7:0]  enable_delay;
        logic        video_standard;
        logic        held_load;
        logic [15:0] held_load_word;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] phase_diff;
        logic               pulse_present;
        logic [15:0]        loop_dac;
        logic [7:0]         utc_valid_bits;
    } in_item_t;

    typedef struct packed {
        logic        locked;
        logic [1:0]  status_bits;
        logic [4:0]  control_word;
        logic [15:0] average_dac;
        logic [15:0] held_dac;
        logic        restore_strobe;
        logic        save_high_strobe;
        logic        save_low_strobe;
    } out_item_t;

    // Boot DAC word: zero selects the default word
    function automatic logic [15:0] boot_word(input logic [15:0] v);
        return (v == 16'd0) ? DEFAULT_DAC : v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/olsup_cfg.sv
// Configuration registers of the oscillator lock supervisor.
`default_nettype none

module olsup_cfg
    import olsup_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    logic [14:0] phase_tol_reg;
    logic [7:0]  dwell_limit_reg;
    logic [7:0]  enable_delay_reg;
    logic        video_std_reg;
    cfg_index_t  index;

    assign index = cfg_index_t'(cfg_index);

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_tol_reg    <= PHASE_TOL_RESET;
            dwell_limit_reg  <= DWELL_LIMIT_RESET;
            enable_delay_reg <= ENABLE_DLY_RESET;
            video_std_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (index)
                CFG_PHASE_TOLERANCE: phase_tol_reg    <= cfg_data[14:0];
                CFG_DWELL_LIMIT:     dwell_limit_reg  <= cfg_data[7:0];
                CFG_ENABLE_DELAY:    enable_delay_reg <= cfg_data[7:0];
                CFG_VIDEO_STANDARD:  video_std_reg    <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Startup word goes straight to the held DAC word in the core
    always_comb
    begin
        cfg.phase_tolerance = phase_tol_reg;
        cfg.dwell_limit     = dwell_limit_reg;
        cfg.enable_delay    = enable_delay_reg;
        cfg.video_standard  = video_std_reg;
        cfg.held_load       = cfg_write && (index == CFG_STARTUP_DAC);
        cfg.held_load_word  = boot_word(cfg_data);
    end

endmodule

`default_nettype wire

>>> rtl/olsup_core.sv
// Per-second lock supervision logic and its state registers.
`default_nettype none

module olsup_core
    import olsup_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      advance,
    input  wire in_item_t  item,
    output out_item_t      result
);

    logic        lock_reg,  lock_next;
    logic [7:0]  dwell_reg, dwell_next;
    logic [7:0]  sec_reg,   sec_next;
    logic [15:0] held_reg,  held_next;
    logic [15:0] avg_reg,   avg_next;
    logic        osc_reg,   osc_next;
    logic        fast_reg,  fast_next;
    logic        fixed_next;

    logic signed [16:0] phase;
    logic signed [16:0] tol;
    logic               pulse;
    logic               in_window;
    logic               out_window;
    logic               qualify;
    logic               expired;
    logic               hold_now;

    // Phase window compare on 17 bits so -tolerance never overflows
    assign phase      = {item.phase_diff[15], item.phase_diff};
    assign tol        = {2'b00, cfg.phase_tolerance};
    assign pulse      = item.pulse_present;
    assign in_window  = (phase < tol) && (phase > -tol);
    assign out_window = (phase > tol) || (phase < -tol);

    // Next state for one second
    always_comb
    begin
        qualify = (!lock_reg && pulse && in_window) || (lock_reg && (!pulse || out_window));
        expired = qualify && (dwell_reg > cfg.dwell_limit);

        dwell_next = dwell_reg;
        if (qualify)
        begin
            if (expired)
                dwell_next = 8'd0;
            else if (dwell_reg != DWELL_TOP)
                dwell_next = dwell_reg + 8'd1;
        end

        lock_next  = expired ? !lock_reg : lock_reg;
        fast_next  = expired ? lock_reg  : fast_reg;
        sec_next   = pulse ? sec_reg + 8'd1 : 8'd0;
        // Fixed mode is set fresh every second from the pulse
        fixed_next = !pulse;

        hold_now  = lock_next && pulse;
        held_next = hold_now ? item.loop_dac : held_reg;
        avg_next  = hold_now
                  ? avg_reg - (avg_reg >> AVG_SHIFT) + (item.loop_dac >> AVG_SHIFT)
                  : avg_reg;

        osc_next = osc_reg;
        if (pulse && (sec_next == cfg.enable_delay) && (item.utc_valid_bits == UTC_ALL_VALID))
            osc_next = 1'b0;

        result.locked           = lock_next;
        result.status_bits      = {lock_next, pulse};
        result.control_word     = {fixed_next, fast_next, osc_next, 1'b0, cfg.video_standard};
        result.average_dac      = avg_next;
        result.held_dac         = held_next;
        result.restore_strobe   = !pulse;
        result.save_high_strobe = hold_now && (sec_next == SAVE_HIGH_SECOND);
        result.save_low_strobe  = hold_now && (sec_next == SAVE_LOW_SECOND);
    end

    // State update when an item enters the result; a held load wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg  <= 1'b0;
            dwell_reg <= 8'd0;
            sec_reg   <= 8'd0;
            held_reg  <= DEFAULT_DAC;
            avg_reg   <= 16'd0;
            osc_reg   <= 1'b1;
            fast_reg  <= 1'b1;
        end
        else if (cfg.held_load)
        begin
            held_reg <= cfg.held_load_word;
        end
        else if (advance)
        begin
            lock_reg  <= lock_next;
            dwell_reg <= dwell_next;
            sec_reg   <= sec_next;
            held_reg  <= held_next;
            avg_reg   <= avg_next;
            osc_reg   <= osc_next;
            fast_reg  <= fast_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/oscillator_lock_supervisor.sv
// Top level of the oscillator lock supervisor: input and result registers.
//
// Usage:
//   One input item per one-second pulse on in_valid/in_stall/in_item.
//   One result item per input item on out_valid/out_stall/out_item.
//   Configuration through cfg_write/cfg_index/cfg_data, written while idle;
//   writing the startup DAC register also reloads the held DAC word.
// Timing:
//   An accepted item is held in the input register, is evaluated by the
//   lock logic and lands in the result register, where out_valid rises.
//   One item per cycle is sustained while out_stall is low; the lock, dwell,
//   second and average state is updated in the same cycle the item enters
//   the result register.
// Reset:
//   rst_n clears both registers' valid bits, restores register defaults,
//   unlocks, selects the fast filter and holds the oscillator in reset.
// Stall:
//   A stalled result holds; the input register still fills, then in_stall
//   rises until the result is taken.
`default_nettype none

module oscillator_lock_supervisor
    import olsup_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_item_t               in_item,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_item_t                   out_item,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg;
    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    out_item_t result;
    logic      advance;
    logic      in_accept;

    olsup_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    olsup_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .item    (s1_item_reg),
        .result  (result)
    );

    // Handshake between input register and result register
    always_comb
    begin
        advance        = s1_valid_reg && (!out_valid_reg || !out_stall);
        in_stall       = s1_valid_reg && !advance;
        in_accept      = in_valid && !in_stall;
        s1_valid_next  = in_accept || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_item_reg <= in_item;
        if (advance)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

>>> rtl/olsup_checker.sv
// Port-level checker of the oscillator lock supervisor, bound to the top level.
`default_nettype none

`include "oscillator_lock_supervisor_assert.svh"

module olsup_checker
    import olsup_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire out_item_t              out_item
);

    // Stalled result holds
    `OLSUP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

    // Lock flag and its status bit agree
    `OLSUP_ASSERT_NOW(a_lock_status, out_valid, out_item.locked == out_item.status_bits[1])

    // Filter choice always follows lock state
    `OLSUP_ASSERT_NOW(a_filter, out_valid, out_item.control_word[3] != out_item.locked)

    // Pulse loss means restore and fixed mode
    `OLSUP_ASSERT_NOW(a_restore, out_valid, (out_item.restore_strobe != out_item.status_bits[0]) && (out_item.control_word[4] == out_item.restore_strobe))

    // Saves only while locked with pulse, never both at once
    `OLSUP_ASSERT_NOW(a_save, out_valid && (out_item.save_high_strobe || out_item.save_low_strobe), out_item.locked && out_item.status_bits[0] && !(out_item.save_high_strobe && out_item.save_low_strobe))

endmodule

bind oscillator_lock_supervisor olsup_checker u_olsup_checker (.*);

`default_nettype wire
